// ===== sv/cle_pkg.sv =====
// shared types and constants for the cursor list engine
`timescale 1ns / 1ps

package cle_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 8;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FOUND_W = IDX_W + 1;
   localparam int REQ_W   = 4;
   localparam int POS_W   = 4;
   localparam int ST_W    = 3;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 4'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 4'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 4'd2;
   localparam logic [REQ_W-1:0] REQ_START  = 4'd3;
   localparam logic [REQ_W-1:0] REQ_END    = 4'd4;
   localparam logic [REQ_W-1:0] REQ_PREV   = 4'd5;
   localparam logic [REQ_W-1:0] REQ_NEXT   = 4'd6;
   localparam logic [REQ_W-1:0] REQ_MOVE   = 4'd7;
   localparam logic [REQ_W-1:0] REQ_READ   = 4'd8;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 4'd9;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 4'd10;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_AT_START = 3'd1;
   localparam logic [ST_W-1:0] ST_AT_END   = 3'd2;
   localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_APPEND,
      CELL_REMOVE
   } cell_op_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] cursor;
      logic [CNT_W-1:0] count;
      logic [WIDTH-1:0] key;
   } cle_cmd_type;

endpackage

// ===== sv/cle_cell.sv =====
// one list entry: shifts with its neighbors, compares against the key
`timescale 1ns / 1ps

module cle_cell
   import cle_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] idx,
   input  cle_cmd_type      cmd,
   input  logic [WIDTH-1:0] left_value,
   input  logic [WIDTH-1:0] right_value,
   output logic [WIDTH-1:0] value,
   output logic [WIDTH-1:0] tap,
   output logic             match
);

   logic [WIDTH-1:0] value_ff, value_in;
   logic             match_ff, match_in;
   logic [CNT_W-1:0] idx_wide;

   assign idx_wide = {1'b0, idx};

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (idx == cmd.cursor) begin
               value_in = cmd.key;
            end else if (idx > cmd.cursor && idx_wide <= cmd.count) begin
               value_in = left_value;
            end
         end
         CELL_APPEND: begin
            if (idx_wide == cmd.count) begin
               value_in = cmd.key;
            end
         end
         CELL_REMOVE: begin
            if (idx >= cmd.cursor && (idx_wide + CNT_W'(1)) < cmd.count) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // only entries below the length take part in a search
   assign match_in = (value_ff == cmd.key) && (idx_wide < cmd.count);

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;
   assign tap   = (idx == cmd.cursor) ? value_ff : '0;

endmodule

// ===== sv/cursor_list_engine.sv =====
// top level of the cursor list engine: controller and row of entry cells
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   req      | req_valid, req_stall | req_type, req_item_value, req_target_position
//   rsp      | rsp_valid, rsp_stall | rsp_read_value, rsp_found_index,
//            |                      | rsp_list_length, rsp_cursor_position, rsp_status
//
// one item at a time: accept, execute in the cells, group encode, final encode,
// then the result waits in its register until rsp is not stalled
// the result is offered in S_RESP after S_EXEC, S_SCAN and S_PACK, the last two for the two-level match encoder
// synchronous reset empties the list and puts the cursor at 0
// req_stall stays high from acceptance until the result has been taken
`timescale 1ns / 1ps

module cursor_list_engine
   import cle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [REQ_W-1:0]          req_type,
   input  logic [WIDTH-1:0]          req_item_value,
   input  logic [POS_W-1:0]          req_target_position,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [WIDTH-1:0]          rsp_read_value,
   output logic signed [FOUND_W-1:0] rsp_found_index,
   output logic [CNT_W-1:0]          rsp_list_length,
   output logic [IDX_W-1:0]          rsp_cursor_position,
   output logic [ST_W-1:0]           rsp_status
);

   localparam int GRP     = 4;
   localparam int GRP_W   = $clog2(GRP);
   localparam int GROUPS  = DEPTH / GRP;
   localparam int GSEL_W  = IDX_W - GRP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_PACK,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [REQ_W-1:0]     code_ff, code_in;
   logic [WIDTH-1:0]     key_ff, key_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [WIDTH-1:0]     rd_ff, rd_in;
   logic [ST_W-1:0]      status_ff, status_in;
   logic [FOUND_W-1:0]   found_ff, found_in;
   logic [GROUPS-1:0]    grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]     grp_idx_ff [GROUPS], grp_idx_in [GROUPS];

   cle_cmd_type          cmd;
   cell_op_type          cell_op;
   logic [WIDTH-1:0]     cell_val [DEPTH];
   logic [WIDTH-1:0]     cell_tap [DEPTH];
   logic [WIDTH-1:0]     nb_left [DEPTH];
   logic [WIDTH-1:0]     nb_right [DEPTH];
   logic [DEPTH-1:0]     match;
   logic [WIDTH-1:0]     tap_or;
   logic [CNT_W-1:0]     count_dec;

   // cell row
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign nb_left[gi] = '0;
         end else begin : g_left
            assign nb_left[gi] = cell_val[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign nb_right[gi] = '0;
         end else begin : g_right
            assign nb_right[gi] = cell_val[gi+1];
         end

         cle_cell u_cell (
            .clock       (clock),
            .idx         (IDX_W'(gi)),
            .cmd         (cmd),
            .left_value  (nb_left[gi]),
            .right_value (nb_right[gi]),
            .value       (cell_val[gi]),
            .tap         (cell_tap[gi]),
            .match       (match[gi])
         );
      end
   endgenerate

   assign cmd.op     = cell_op;
   assign cmd.cursor = cursor_ff;
   assign cmd.count  = count_ff;
   assign cmd.key    = key_ff;

   // only the cell under the cursor drives a nonzero tap
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   // first level of the match encoder, lowest index wins
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = |match[g*GRP +: GRP];
         grp_idx_in[g] = '0;
         for (int j = GRP - 1; j >= 0; j--) begin
            if (match[g*GRP + j]) begin
               grp_idx_in[g] = GRP_W'(j);
            end
         end
      end
   end

   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      rd_in     = rd_ff;
      status_in = status_ff;
      found_in  = found_ff;
      cell_op   = CELL_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code_in  = req_type;
               key_in   = req_item_value;
               pos_in   = req_target_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rd_in     = '0;
            status_in = ST_OK;
            found_in  = '0;
            case (code_ff)
               REQ_INSERT: begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     cell_op  = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               REQ_APPEND: begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     cell_op  = CELL_APPEND;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               REQ_REMOVE: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cell_op  = CELL_REMOVE;
                     rd_in    = tap_or;
                     count_in = count_dec;
                     // cursor was on the last entry
                     if ({1'b0, cursor_ff} == count_dec && cursor_ff != '0) begin
                        cursor_in = cursor_ff - IDX_W'(1);
                     end
                  end
               end
               REQ_START: begin
                  cursor_in = '0;
               end
               REQ_END: begin
                  if (count_ff == '0) begin
                     cursor_in = '0;
                     status_in = ST_EMPTY;
                  end else begin
                     cursor_in = count_dec[IDX_W-1:0];
                  end
               end
               REQ_PREV: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (cursor_ff == '0) begin
                     status_in = ST_AT_START;
                  end else begin
                     cursor_in = cursor_ff - IDX_W'(1);
                  end
               end
               REQ_NEXT: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (({1'b0, cursor_ff} + CNT_W'(1)) >= count_ff) begin
                     status_in = ST_AT_END;
                  end else begin
                     cursor_in = cursor_ff + IDX_W'(1);
                  end
               end
               REQ_MOVE: begin
                  if (CNT_W'(pos_ff) >= count_ff) begin
                     status_in = ST_RANGE;
                  end else begin
                     cursor_in = pos_ff[IDX_W-1:0];
                  end
               end
               REQ_READ: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     rd_in = tap_or;
                  end
               end
               REQ_CLEAR: begin
                  count_in  = '0;
                  cursor_in = '0;
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
            state_in = S_SCAN;
         end
         S_SCAN: begin
            state_in = S_PACK;
         end
         S_PACK: begin
            if (code_ff == REQ_SEARCH) begin
               found_in = '1;
               for (int g = GROUPS - 1; g >= 0; g--) begin
                  if (grp_any_ff[g]) begin
                     found_in = FOUND_W'({GSEL_W'(g), grp_idx_ff[g]});
                  end
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      code_ff    <= code_in;
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      rd_ff      <= rd_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      grp_any_ff <= grp_any_in;
      grp_idx_ff <= grp_idx_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_RESP);
   assign rsp_read_value      = rd_ff;
   assign rsp_found_index     = found_ff;
   assign rsp_list_length     = count_ff;
   assign rsp_cursor_position = cursor_ff;
   assign rsp_status          = status_ff;

`ifndef SYNTHESIS
   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) ? (cursor_ff == '0) : ({1'b0, cursor_ff} < count_ff))
      else $error("cursor outside the list");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("length beyond depth");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##4 rsp_valid)
      else $error("result not ready four cycles after acceptance");

   a_found_only_search: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && found_ff != '0) |-> (code_ff == REQ_SEARCH))
      else $error("search index on a non-search item");
`endif

endmodule

// ===== dv/cle_list_checker.sv =====
// checker for the cursor list engine: list predictor and result scoreboard
`timescale 1ns / 1ps

module cle_list_checker
   import cle_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [REQ_W-1:0]          req_type,
   input  logic [WIDTH-1:0]          req_item_value,
   input  logic [POS_W-1:0]          req_target_position,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [WIDTH-1:0]          rsp_read_value,
   input  logic signed [FOUND_W-1:0] rsp_found_index,
   input  logic [CNT_W-1:0]          rsp_list_length,
   input  logic [IDX_W-1:0]          rsp_cursor_position,
   input  logic [ST_W-1:0]           rsp_status,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic [WIDTH-1:0]          read_value;
      logic signed [FOUND_W-1:0] found_index;
      logic [CNT_W-1:0]          list_length;
      logic [IDX_W-1:0]          cursor_position;
      logic [ST_W-1:0]           status;
   } list_result_type;

   logic [WIDTH-1:0] list_mem [DEPTH];
   int               list_len;
   int               list_cur;
   list_result_type  expected_q [$];
   int               err_total;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      err_total     = 0;
   end

   function automatic list_result_type list_apply(logic [REQ_W-1:0] op,
                                                  logic [WIDTH-1:0] val,
                                                  logic [POS_W-1:0] pos);
      list_result_type r;
      int              i;
      logic            hit;
      r   = '0;
      hit = 1'b0;
      case (op)
         REQ_INSERT: begin
            if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_len; i > list_cur; i--) list_mem[i] = list_mem[i-1];
               list_mem[list_cur] = val;
               list_len++;
            end
         end
         REQ_APPEND: begin
            if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         REQ_REMOVE: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_value = list_mem[list_cur];
               for (i = list_cur; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
               // cursor on the old tail steps back
               if (list_cur == list_len && list_cur > 0) list_cur--;
            end
         end
         REQ_START: list_cur = 0;
         REQ_END: begin
            if (list_len == 0) begin
               list_cur = 0;
               r.status = ST_EMPTY;
            end else begin
               list_cur = list_len - 1;
            end
         end
         REQ_PREV: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (list_cur == 0) r.status = ST_AT_START;
            else list_cur--;
         end
         REQ_NEXT: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (list_cur + 1 >= list_len) r.status = ST_AT_END;
            else list_cur++;
         end
         REQ_MOVE: begin
            if (int'(pos) >= list_len) r.status = ST_RANGE;
            else list_cur = int'(pos);
         end
         REQ_READ: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else r.read_value = list_mem[list_cur];
         end
         REQ_SEARCH: begin
            r.found_index = '1;
            for (i = 0; i < list_len; i++) begin
               if (!hit && list_mem[i] == val) begin
                  r.found_index = FOUND_W'(i);
                  hit = 1'b1;
               end
            end
         end
         REQ_CLEAR: begin
            list_len = 0;
            list_cur = 0;
         end
         default: ;
      endcase
      r.list_length     = CNT_W'(list_len);
      r.cursor_position = IDX_W'(list_cur);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         err_total++;
      end
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
         list_len = 0;
         list_cur = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result with no item pending, got length %0d cursor %0d status %0d",
                        $time, rsp_list_length, rsp_cursor_position, rsp_status);
               err_total++;
            end else begin
               want = expected_q.pop_front();
               check_field("read_value", 32'(want.read_value), 32'(rsp_read_value));
               check_field("found_index", 32'(want.found_index), 32'(rsp_found_index));
               check_field("list_length", 32'(want.list_length), 32'(rsp_list_length));
               check_field("cursor_position", 32'(want.cursor_position),
                           32'(rsp_cursor_position));
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(list_apply(req_type, req_item_value, req_target_position));
      end
      fail_count    <= err_total;
      pending_count <= expected_q.size();
   end

endmodule

// ===== dv/tb_cursor_list_engine.sv =====
// testbench top for the cursor list engine: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_cursor_list_engine;
   import cle_pkg::*;

   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 4'd11;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 4'd15;
   localparam int RANDOM_ITEMS = 1500;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_WALK  = 2;
   localparam int MODE_NOISE = 3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [REQ_W-1:0]          req_type = '0;
   logic [WIDTH-1:0]          req_item_value = '0;
   logic [POS_W-1:0]          req_target_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [WIDTH-1:0]          rsp_read_value;
   logic signed [FOUND_W-1:0] rsp_found_index;
   logic [CNT_W-1:0]          rsp_list_length;
   logic [IDX_W-1:0]          rsp_cursor_position;
   logic [ST_W-1:0]           rsp_status;
   int                        fail_count;
   int                        pending_count;
   int                        idle_pct = 7;
   int                        quiet_cycles = 0;

   logic [REQ_W-1:0] walk_ops [7] = '{REQ_START, REQ_END, REQ_PREV, REQ_NEXT,
                                      REQ_MOVE, REQ_READ, REQ_SEARCH};

   cursor_list_engine dut (.*);
   cle_list_checker checker_i (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [REQ_W-1:0] op, logic [WIDTH-1:0] val,
                            logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= op;
      req_item_value      <= val;
      req_target_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly a small pool of values so searches hit, sometimes the full range
   function automatic logic [WIDTH-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return WIDTH'($urandom_range(0, 255));
      return WIDTH'($urandom_range(0, 7));
   endfunction

   function automatic logic [REQ_W-1:0] pick_op(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (roll < 40) return REQ_APPEND;
            if (roll < 78) return REQ_INSERT;
         end
         MODE_DRAIN: begin
            if (roll < 60) return REQ_REMOVE;
         end
         MODE_WALK: begin
            if (roll < 8) return REQ_INSERT;
            if (roll < 16) return REQ_REMOVE;
            if (roll < 18) return REQ_CLEAR;
         end
         default: return REQ_W'($urandom_range(0, 15));
      endcase
      return walk_ops[$urandom_range(0, 6)];
   endfunction

   task automatic run_random(int n);
      int k;
      int mode;
      int burst_left;
      mode       = MODE_FILL;
      burst_left = 0;
      for (k = 0; k < n; k++) begin
         if (burst_left == 0) begin
            mode       = $urandom_range(0, 9) == 0 ? MODE_NOISE : $urandom_range(0, 2);
            burst_left = $urandom_range(10, 40);
         end
         burst_left--;
         // a long stretch with no idling on either side
         idle_pct = (k >= n / 3 && k < n / 2) ? 0 : 7;
         send_item(pick_op(mode), pick_value(), POS_W'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners
      send_item(REQ_READ, 8'h00, 4'd0);
      send_item(REQ_REMOVE, 8'h00, 4'd0);
      send_item(REQ_END, 8'h00, 4'd0);
      send_item(REQ_PREV, 8'h00, 4'd0);
      send_item(REQ_NEXT, 8'h00, 4'd0);
      send_item(REQ_SEARCH, 8'h00, 4'd0);
      send_item(REQ_MOVE, 8'h00, 4'd0);
      send_item(REQ_START, 8'h00, 4'd0);
      send_item(REQ_SPARE_HI, 8'hff, 4'd15);
      // short list, cursor walks and refused moves
      send_item(REQ_APPEND, 8'h00, 4'd0);
      send_item(REQ_APPEND, 8'hff, 4'd0);
      send_item(REQ_INSERT, 8'ha5, 4'd0);
      send_item(REQ_PREV, 8'h00, 4'd0);
      send_item(REQ_NEXT, 8'h00, 4'd0);
      send_item(REQ_NEXT, 8'h00, 4'd0);
      send_item(REQ_NEXT, 8'h00, 4'd0);
      send_item(REQ_MOVE, 8'h00, 4'd15);
      send_item(REQ_MOVE, 8'h00, 4'd1);
      send_item(REQ_READ, 8'h00, 4'd0);
      send_item(REQ_SEARCH, 8'hff, 4'd0);
      send_item(REQ_SEARCH, 8'h5a, 4'd0);
      send_item(REQ_SPARE_LO, 8'h00, 4'd0);
      // remove on the tail pulls the cursor back
      send_item(REQ_END, 8'h00, 4'd0);
      send_item(REQ_REMOVE, 8'h00, 4'd0);
      send_item(REQ_CLEAR, 8'h00, 4'd0);

      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;
      idle_pct  = 7;

      // let the pending count see the last item before waiting on it
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== cursor_list_engine.f =====
sv/cle_pkg.sv
sv/cle_cell.sv
sv/cursor_list_engine.sv
dv/cle_list_checker.sv
dv/tb_cursor_list_engine.sv
